>>> design/tcts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed command table scheduler package
// Shared constants, codes and record types for the scheduler core, its
// table entries and its testbench.
// ----------------------------------------------------------------------------
package tcts_pkg;

    // Table geometry and result limit.
    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int NOW_W   = 48;
    localparam int END_W   = NOW_W + 1;
    localparam int ID_W    = 16;
    localparam int MODEL_W = 3;
    localparam int KIND_W  = 3;
    localparam int LEVEL_W = 8;
    localparam int DUR_W   = 16;
    localparam int HOLD_W  = 16;

    // Configuration register map and reset values.
    localparam logic [0:0]        REG_STOP_HOLD  = 1'b0;
    localparam logic [HOLD_W-1:0] STOP_HOLD_RST  = 16'd300;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SCAN   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Event codes carried on the output tuser.
    typedef enum logic [2:0] {
        EV_ADDED     = 3'd0,
        EV_REPLACED  = 3'd1,
        EV_DISCARDED = 3'd2,
        EV_DROPPED   = 3'd3,
        EV_ACTIVE    = 3'd4,
        EV_STOP      = 3'd5
    } ev_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_END,
        ST_FLUSH
    } state_t;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic [END_W-1:0]   end_ms;
        logic [ID_W-1:0]    id;
        logic [MODEL_W-1:0] model;
        logic [KIND_W-1:0]  kind;
        logic [LEVEL_W-1:0] level;
        logic               may_replace;
        logic               has_seq;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result record.
    typedef struct packed {
        ev_t                ev;
        logic [ID_W-1:0]    id;
        logic [MODEL_W-1:0] model;
        logic [KIND_W-1:0]  kind;
        logic [LEVEL_W-1:0] level;
    } result_t;

endpackage

>>> design/tcts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data; contents are
// undefined until written.
// ----------------------------------------------------------------------------
module tcts_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> design/timed_command_table_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed command table scheduler core
// Keeps an ordered table of timed commands, one per target id, in a small
// memory; inserts, scans with in-place compaction, and clears it.
// ----------------------------------------------------------------------------
// Operation: a scan walks every entry and an insert walks until it finds the
// same id, with one registered table read per entry; both then pass through
// a commit state and a flush state before the next item is accepted. The
// result consumer can stall a scan walk and the flush by holding tready low.
// A clear or an unknown operation completes in the idle state.
// Reset: entry count cleared, stop hold 300 ms, memory left undefined.
module timed_command_table_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: shocker_id[15:0], model[18:16], command_type[21:19],
    // intensity[29:22], duration_ms[45:30], overwrite[46],
    // sequence_present[47], now_ms[95:48]
    input  logic [95:0] s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: target_id[15:0], out_model[18:16], out_command_type[21:19],
    // out_intensity[29:22], zero[31:30]
    output logic [31:0] m_axis_tdata,
    // tuser: event_res[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = tcts_pkg::IDX_W;
    localparam int CW = tcts_pkg::CNT_W;
    localparam int RW = tcts_pkg::RES_W;
    localparam int NW = tcts_pkg::NOW_W;

    // Control state.
    tcts_pkg::state_t  state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [tcts_pkg::HOLD_W-1:0] hold_reg;
    logic [CW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic              dv_reg, dv_next;
    logic [IW-1:0]     di_reg, di_next;
    logic [CW-1:0]     wr_reg, wr_next;
    logic [RW-1:0]     nres_reg, nres_next;
    logic              match_reg, match_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;

    // Payload state.
    tcts_pkg::entry_t  cmd_reg, cmd_next;
    logic [NW-1:0]     now_reg, now_next;
    logic [NW-1:0]     rm_thr_reg, rm_thr_next;
    logic              rm_en_reg, rm_en_next;
    logic [IW-1:0]     match_idx_reg, match_idx_next;
    logic              match_ovw_reg, match_ovw_next;
    tcts_pkg::result_t pend_reg, pend_next;
    tcts_pkg::result_t out_reg, out_next;
    logic              out_last_reg, out_last_next;

    // Table memory port signals.
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    logic [tcts_pkg::ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]                ram_raddr;
    logic [tcts_pkg::ENTRY_W-1:0] ram_rdata;
    tcts_pkg::entry_t             rd_entry;

    // Walk decisions.
    logic in_accept;
    logic out_accept;
    logic emit_ok;
    logic is_scan;
    logic expired;
    logic removed;
    logic send;
    logic id_hit;
    logic stall;
    logic more;
    logic walk_done;
    logic cfg_write;

    tcts_ram #(
        .WIDTH (tcts_pkg::ENTRY_W),
        .DEPTH (tcts_pkg::TABLE_DEPTH),
        .ADDR_W(IW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Configuration port: single stop hold register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2:2] == tcts_pkg::REG_STOP_HOLD)
        begin
            prdata = {16'd0, hold_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= tcts_pkg::STOP_HOLD_RST;
        end
        else if (cfg_write && (paddr[2:2] == tcts_pkg::REG_STOP_HOLD))
        begin
            hold_reg <= pwdata[tcts_pkg::HOLD_W-1:0];
        end
    end

    // Handshakes and per-entry decisions on the data read last cycle.
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign emit_ok    = !out_valid_reg || m_axis_tready;
    assign rd_entry   = tcts_pkg::entry_t'(ram_rdata);
    assign is_scan    = (op_reg == tcts_pkg::OP_SCAN);
    assign expired    = rd_entry.end_ms < {1'b0, now_reg};
    assign removed    = expired && rm_en_reg && (rd_entry.end_ms < {1'b0, rm_thr_reg});
    assign send       = is_scan && dv_reg && rd_entry.has_seq
                        && (nres_reg < RW'(tcts_pkg::MAX_RESULTS));
    assign id_hit     = !is_scan && dv_reg && (rd_entry.id == cmd_reg.id);
    assign stall      = (state_reg == tcts_pkg::ST_WALK) && send && pend_valid_reg && !emit_ok;
    assign more       = rd_ptr_reg < count_reg;
    assign walk_done  = !stall && (id_hit || !more);

    // A stalled walk re-reads the entry it holds so the read data stays put.
    assign ram_raddr  = stall ? di_reg : rd_ptr_reg[IW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcts_pkg::ST_IDLE:
            begin
                if (in_accept && ((s_axis_tuser == tcts_pkg::OP_INSERT)
                                  || (s_axis_tuser == tcts_pkg::OP_SCAN)))
                begin
                    state_next = tcts_pkg::ST_WALK;
                end
            end
            tcts_pkg::ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = tcts_pkg::ST_END;
                end
            end
            tcts_pkg::ST_END:
            begin
                state_next = tcts_pkg::ST_FLUSH;
            end
            tcts_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg || emit_ok)
                begin
                    state_next = tcts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcts_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory and result updates per state.
    always_comb
    begin
        s_axis_tready   = 1'b0;
        op_next         = op_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        dv_next         = dv_reg;
        di_next         = di_reg;
        wr_next         = wr_reg;
        nres_next       = nres_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        match_ovw_next  = match_ovw_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        rm_thr_next     = rm_thr_reg;
        rm_en_next      = rm_en_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_reg[IW-1:0];
        ram_wdata       = rd_entry;

        // The consumer takes the held result.
        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tcts_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    op_next              = s_axis_tuser;
                    cmd_next.id          = s_axis_tdata[15:0];
                    cmd_next.model       = s_axis_tdata[18:16];
                    cmd_next.kind        = s_axis_tdata[21:19];
                    cmd_next.level       = s_axis_tdata[29:22];
                    cmd_next.end_ms      = {1'b0, s_axis_tdata[95:48]}
                                           + tcts_pkg::END_W'(s_axis_tdata[45:30]);
                    cmd_next.may_replace = s_axis_tdata[46];
                    cmd_next.has_seq     = s_axis_tdata[47];
                    now_next             = s_axis_tdata[95:48];
                    rm_thr_next          = s_axis_tdata[95:48] - NW'(hold_reg);
                    rm_en_next           = s_axis_tdata[95:48] >= NW'(hold_reg);
                    rd_ptr_next          = '0;
                    dv_next              = 1'b0;
                    wr_next              = '0;
                    nres_next            = '0;
                    match_next           = 1'b0;
                    if (s_axis_tuser == tcts_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            tcts_pkg::ST_WALK:
            begin
                if (!stall)
                begin
                    // Issue the next read.
                    if (more)
                    begin
                        dv_next     = 1'b1;
                        di_next     = rd_ptr_reg[IW-1:0];
                        rd_ptr_next = rd_ptr_reg + CW'(1);
                    end
                    else
                    begin
                        dv_next = 1'b0;
                    end
                    // Insert: look for the same id.
                    if (id_hit)
                    begin
                        match_next     = 1'b1;
                        match_idx_next = di_reg;
                        match_ovw_next = rd_entry.may_replace;
                    end
                    // Scan: report sends, one held back to mark the last.
                    if (send)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next.ev    = expired ? tcts_pkg::EV_STOP : tcts_pkg::EV_ACTIVE;
                        pend_next.id    = rd_entry.id;
                        pend_next.model = rd_entry.model;
                        pend_next.kind  = rd_entry.kind;
                        pend_next.level = rd_entry.level;
                        nres_next       = nres_reg + RW'(1);
                    end
                    // Scan: compact the surviving entries toward the front.
                    if (is_scan && dv_reg && !removed)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_reg[IW-1:0];
                        ram_wdata = rd_entry;
                        wr_next   = wr_reg + CW'(1);
                    end
                end
            end
            tcts_pkg::ST_END:
            begin
                if (is_scan)
                begin
                    count_next = wr_reg;
                end
                else
                begin
                    // Insert outcome.
                    pend_valid_next = 1'b1;
                    pend_next.id    = cmd_reg.id;
                    pend_next.model = cmd_reg.model;
                    pend_next.kind  = cmd_reg.kind;
                    pend_next.level = cmd_reg.level;
                    ram_wdata       = cmd_reg;
                    if (match_reg)
                    begin
                        ram_waddr = match_idx_reg;
                        if (match_ovw_reg)
                        begin
                            ram_we       = 1'b1;
                            pend_next.ev = tcts_pkg::EV_REPLACED;
                        end
                        else
                        begin
                            pend_next.ev = tcts_pkg::EV_DISCARDED;
                        end
                    end
                    else if (count_reg < CW'(tcts_pkg::TABLE_DEPTH))
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = count_reg[IW-1:0];
                        count_next   = count_reg + CW'(1);
                        pend_next.ev = tcts_pkg::EV_ADDED;
                    end
                    else
                    begin
                        pend_next.ev = tcts_pkg::EV_DROPPED;
                    end
                end
            end
            tcts_pkg::ST_FLUSH:
            begin
                if (pend_valid_reg && emit_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcts_pkg::ST_IDLE;
            op_reg         <= '0;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            dv_reg         <= 1'b0;
            di_reg         <= '0;
            wr_reg         <= '0;
            nres_reg       <= '0;
            match_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            count_reg      <= count_next;
            rd_ptr_reg     <= rd_ptr_next;
            dv_reg         <= dv_next;
            di_reg         <= di_next;
            wr_reg         <= wr_next;
            nres_reg       <= nres_next;
            match_reg      <= match_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        now_reg       <= now_next;
        rm_thr_reg    <= rm_thr_next;
        rm_en_reg     <= rm_en_next;
        match_idx_reg <= match_idx_next;
        match_ovw_reg <= match_ovw_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    // Result stream outputs.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.level, out_reg.kind, out_reg.model, out_reg.id};
    assign m_axis_tuser  = out_reg.ev;
    assign m_axis_tlast  = out_last_reg;

    // The table never holds more entries than it has rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(tcts_pkg::TABLE_DEPTH))
    else $error("entry count exceeds table depth");

    // Compaction never writes ahead of the entry being examined.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == tcts_pkg::ST_WALK) && dv_reg && is_scan) |-> (wr_reg <= CW'(di_reg)))
    else $error("compaction write pointer passed read data");

    // A clear empties the table at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == tcts_pkg::OP_CLEAR)) |=> (count_reg == '0))
    else $error("clear did not empty the table");

endmodule

>>> tb/sv/timed_command_table_scheduler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed command table scheduler core testbench
// Drives insert, scan, clear and unknown-operation transactions into the
// core and checks every result transaction against a cycle-free model of the
// command table. The run opens with a short directed sequence (duplicate ids,
// expiry and removal boundaries, a full table) and then follows with random
// traffic under several stop hold settings. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module timed_command_table_scheduler_core_tb;

    localparam logic [1:0] OP_UNKNOWN    = 2'd3;
    localparam logic [2:0] HOLD_ADDR     = {tcts_pkg::REG_STOP_HOLD, 2'b00};
    localparam logic [2:0] SPARE_ADDR    = 3'd4;
    localparam int         IDLE_PCT      = 37;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         ID_POOL_SIZE  = 20;
    localparam int         PHASE_ITEMS   = 95;

    // One input command as seen on the slave stream.
    typedef struct {
        logic [1:0]                   op;
        logic [tcts_pkg::ID_W-1:0]    id;
        logic [tcts_pkg::MODEL_W-1:0] model;
        logic [tcts_pkg::KIND_W-1:0]  kind;
        logic [tcts_pkg::LEVEL_W-1:0] level;
        logic [tcts_pkg::DUR_W-1:0]   dur;
        logic                         ovw;
        logic                         seq;
        logic [tcts_pkg::NOW_W-1:0]   now;
    } cmd_item_t;

    // One stored table entry of the model.
    typedef struct {
        logic [tcts_pkg::END_W-1:0]   end_ms;
        logic [tcts_pkg::ID_W-1:0]    id;
        logic [tcts_pkg::MODEL_W-1:0] model;
        logic [tcts_pkg::KIND_W-1:0]  kind;
        logic [tcts_pkg::LEVEL_W-1:0] level;
        logic                         may_replace;
        logic                         has_seq;
    } cmd_slot_t;

    // One result transaction.
    typedef struct {
        tcts_pkg::ev_t                ev;
        logic [tcts_pkg::ID_W-1:0]    id;
        logic [tcts_pkg::MODEL_W-1:0] model;
        logic [tcts_pkg::KIND_W-1:0]  kind;
        logic [tcts_pkg::LEVEL_W-1:0] level;
        logic                         last;
    } tx_event_t;

    // One directed row; typed rows carry their own expected event code.
    typedef struct {
        cmd_item_t     cmd;
        bit            typed;
        tcts_pkg::ev_t ev;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Model state and scoreboard.
    cmd_slot_t                   slot_table [tcts_pkg::TABLE_DEPTH];
    int                          slot_count;
    logic [tcts_pkg::HOLD_W-1:0] hold_ms;
    tx_event_t                   step_events [$];
    tx_event_t                   pending_events [$];
    stim_row_t                   directed [$];
    logic [tcts_pkg::ID_W-1:0]   id_pool [ID_POOL_SIZE];
    logic [tcts_pkg::NOW_W-1:0]  now_ms;
    bit                          idle_on;
    int                          err_count;

    timed_command_table_scheduler_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void push_event(input tcts_pkg::ev_t ev,
                                       input logic [tcts_pkg::ID_W-1:0] id,
                                       input logic [tcts_pkg::MODEL_W-1:0] model,
                                       input logic [tcts_pkg::KIND_W-1:0] kind,
                                       input logic [tcts_pkg::LEVEL_W-1:0] level);
        tx_event_t e;
        e.ev    = ev;
        e.id    = id;
        e.model = model;
        e.kind  = kind;
        e.level = level;
        e.last  = 1'b0;
        step_events.insert(step_events.size(), e);
    endfunction

    // Apply one command to the table model and collect the events it causes.
    function automatic void schedule_cmd(input cmd_item_t c);
        cmd_slot_t                s;
        int                       hit;
        int                       wr;
        tcts_pkg::ev_t            ev;
        logic                     expired;
        logic [tcts_pkg::END_W:0] linger;
        step_events.delete();
        case (c.op)
            tcts_pkg::OP_INSERT:
            begin
                s.end_ms      = tcts_pkg::END_W'(c.now) + tcts_pkg::END_W'(c.dur);
                s.id          = c.id;
                s.model       = c.model;
                s.kind        = c.kind;
                s.level       = c.level;
                s.may_replace = c.ovw;
                s.has_seq     = c.seq;
                hit = -1;
                for (int i = 0; i < slot_count; i++)
                begin
                    if (hit < 0 && slot_table[i].id == c.id)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    if (slot_table[hit].may_replace)
                    begin
                        slot_table[hit] = s;
                        ev = tcts_pkg::EV_REPLACED;
                    end
                    else
                        ev = tcts_pkg::EV_DISCARDED;
                end
                else if (slot_count < tcts_pkg::TABLE_DEPTH)
                begin
                    slot_table[slot_count] = s;
                    slot_count++;
                    ev = tcts_pkg::EV_ADDED;
                end
                else
                    ev = tcts_pkg::EV_DROPPED;
                push_event(ev, c.id, c.model, c.kind, c.level);
            end
            tcts_pkg::OP_SCAN:
            begin
                wr = 0;
                for (int i = 0; i < slot_count; i++)
                begin
                    s = slot_table[i];
                    expired = s.end_ms < {1'b0, c.now};
                    if (s.has_seq && step_events.size() < tcts_pkg::MAX_RESULTS)
                        push_event(expired ? tcts_pkg::EV_STOP : tcts_pkg::EV_ACTIVE,
                                   s.id, s.model, s.kind, s.level);
                    // Entries past end time plus hold are compacted out.
                    linger = {1'b0, s.end_ms} + (tcts_pkg::END_W + 1)'(hold_ms);
                    if (!(expired && linger < (tcts_pkg::END_W + 1)'(c.now)))
                    begin
                        slot_table[wr] = s;
                        wr++;
                    end
                end
                slot_count = wr;
            end
            tcts_pkg::OP_CLEAR:
                slot_count = 0;
            default:
                ;
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    function automatic cmd_item_t mk_cmd(input logic [1:0] op,
                                         input logic [tcts_pkg::ID_W-1:0] id,
                                         input logic [tcts_pkg::MODEL_W-1:0] model,
                                         input logic [tcts_pkg::KIND_W-1:0] kind,
                                         input logic [tcts_pkg::LEVEL_W-1:0] level,
                                         input logic [tcts_pkg::DUR_W-1:0] dur,
                                         input logic ovw, input logic seq,
                                         input logic [tcts_pkg::NOW_W-1:0] now);
        cmd_item_t c;
        c.op    = op;
        c.id    = id;
        c.model = model;
        c.kind  = kind;
        c.level = level;
        c.dur   = dur;
        c.ovw   = ovw;
        c.seq   = seq;
        c.now   = now;
        return c;
    endfunction

    // Append one directed row.
    function automatic void add_row(input cmd_item_t c, input bit typed,
                                    input tcts_pkg::ev_t ev);
        stim_row_t r;
        r.cmd   = c;
        r.typed = typed;
        r.ev    = ev;
        directed.insert(directed.size(), r);
    endfunction

    // Random command: mostly inserts and scans over a small id pool so that
    // matches, replacements and a full table come up often.
    function automatic cmd_item_t next_random_cmd();
        cmd_item_t c;
        int        r;
        r = $urandom_range(99);
        if (r < 55)
            c.op = tcts_pkg::OP_INSERT;
        else if (r < 93)
            c.op = tcts_pkg::OP_SCAN;
        else if (r < 97)
            c.op = tcts_pkg::OP_CLEAR;
        else
            c.op = OP_UNKNOWN;
        if ($urandom_range(99) < 85)
            c.id = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
        else
            c.id = tcts_pkg::ID_W'($urandom);
        c.model = tcts_pkg::MODEL_W'($urandom);
        c.kind  = tcts_pkg::KIND_W'($urandom);
        c.level = tcts_pkg::LEVEL_W'($urandom);
        r = $urandom_range(9);
        if (r == 0)
            c.dur = '0;
        else if (r == 1)
            c.dur = '1;
        else if (r < 4)
            c.dur = tcts_pkg::DUR_W'($urandom);
        else
            c.dur = tcts_pkg::DUR_W'($urandom_range(0, 1500));
        c.ovw = 1'($urandom_range(1));
        c.seq = ($urandom_range(3) != 0);
        if ($urandom_range(19) == 0)
            now_ms = now_ms + tcts_pkg::NOW_W'($urandom_range(2000, 80000));
        else
            now_ms = now_ms + tcts_pkg::NOW_W'($urandom_range(0, 250));
        c.now = now_ms;
        return c;
    endfunction

    // Send one command transaction and record what it should produce.
    task automatic drive_cmd(input stim_row_t row);
        tx_event_t typed_ev;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.cmd.op;
        s_axis_tdata  <= {row.cmd.now, row.cmd.seq, row.cmd.ovw, row.cmd.dur,
                          row.cmd.level, row.cmd.kind, row.cmd.model, row.cmd.id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        schedule_cmd(row.cmd);
        if (row.typed)
        begin
            typed_ev.ev    = row.ev;
            typed_ev.id    = row.cmd.id;
            typed_ev.model = row.cmd.model;
            typed_ev.kind  = row.cmd.kind;
            typed_ev.level = row.cmd.level;
            typed_ev.last  = 1'b1;
            pending_events.insert(pending_events.size(), typed_ev);
        end
        else
            foreach (step_events[k])
                pending_events.insert(pending_events.size(), step_events[k]);
        @(negedge clk);
    endtask

    // Hold the input side until all results are in and the core is idle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write followed by a read back of the same address.
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == HOLD_ADDR)
            hold_ms = data[tcts_pkg::HOLD_W-1:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == HOLD_ADDR && prdata !== 32'(hold_ms))
        begin
            $display("%0t: stop hold read back mismatch: expected %0d, actual %0d",
                     $time, hold_ms, prdata);
            err_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side back-pressure.
    always @(negedge clk)
    begin
        m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each result transaction with the oldest expected one.
    always @(posedge clk)
    begin
        tx_event_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected result: ev=%0d tdata=%h last=%b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                err_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (m_axis_tuser !== want.ev || m_axis_tdata[15:0] !== want.id ||
                    m_axis_tdata[18:16] !== want.model ||
                    m_axis_tdata[21:19] !== want.kind ||
                    m_axis_tdata[29:22] !== want.level ||
                    m_axis_tdata[31:30] !== 2'b00 || m_axis_tlast !== want.last)
                begin
                    $display("%0t: expected ev=%0d id=%h mdl=%0d kind=%0d lvl=%0d pad=0 last=%b",
                             $time, want.ev, want.id, want.model, want.kind, want.level,
                             want.last);
                    $display("%0t: actual   ev=%0d id=%h mdl=%0d kind=%0d lvl=%0d pad=%0d last=%b",
                             $time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[18:16],
                             m_axis_tdata[21:19], m_axis_tdata[29:22], m_axis_tdata[31:30],
                             m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        stim_row_t                   row;
        logic [tcts_pkg::HOLD_W-1:0] new_hold;
        logic [tcts_pkg::NOW_W-1:0]  base;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_on       = 1'b1;
        slot_count    = 0;
        hold_ms       = tcts_pkg::STOP_HOLD_RST;
        err_count     = 0;
        now_ms        = 48'd3000;
        for (int i = 0; i < ID_POOL_SIZE; i++)
            id_pool[i] = tcts_pkg::ID_W'($urandom);

        // Field extremes and duplicate ids with both overwrite flag values.
        add_row(mk_cmd(tcts_pkg::OP_INSERT, 16'h0000, 3'd0, 3'd0, 8'd0, 16'd0,
                       1'b1, 1'b1, 48'd1000), 1'b1, tcts_pkg::EV_ADDED);
        add_row(mk_cmd(tcts_pkg::OP_INSERT, 16'hFFFF, 3'd7, 3'd7, 8'd255, 16'hFFFF,
                       1'b0, 1'b1, 48'd1000), 1'b1, tcts_pkg::EV_ADDED);
        add_row(mk_cmd(tcts_pkg::OP_INSERT, 16'hFFFF, 3'd1, 3'd2, 8'd3, 16'd5,
                       1'b1, 1'b0, 48'd1000), 1'b1, tcts_pkg::EV_DISCARDED);
        add_row(mk_cmd(tcts_pkg::OP_INSERT, 16'h0000, 3'd5, 3'd3, 8'd170, 16'd500,
                       1'b0, 1'b1, 48'd1000), 1'b1, tcts_pkg::EV_REPLACED);
        // An entry without a sequence stays silent until removed.
        add_row(mk_cmd(tcts_pkg::OP_INSERT, 16'h1234, 3'd2, 3'd6, 8'd85, 16'd10,
                       1'b1, 1'b0, 48'd1000), 1'b1, tcts_pkg::EV_ADDED);
        // Scans around the expiry and removal boundaries of id 0 (end 1500).
        add_row(mk_cmd(tcts_pkg::OP_SCAN, 16'h5A5A, 3'd0, 3'd0, 8'd0, 16'd0,
                       1'b0, 1'b0, 48'd1200), 1'b0, tcts_pkg::EV_ADDED);
        add_row(mk_cmd(tcts_pkg::OP_SCAN, 16'h0000, 3'd0, 3'd0, 8'd0, 16'd0,
                       1'b0, 1'b0, 48'd1501), 1'b0, tcts_pkg::EV_ADDED);
        add_row(mk_cmd(tcts_pkg::OP_SCAN, 16'h0000, 3'd0, 3'd0, 8'd0, 16'd0,
                       1'b0, 1'b0, 48'd1800), 1'b0, tcts_pkg::EV_ADDED);
        add_row(mk_cmd(tcts_pkg::OP_SCAN, 16'h0000, 3'd0, 3'd0, 8'd0, 16'd0,
                       1'b0, 1'b0, 48'd1801), 1'b0, tcts_pkg::EV_ADDED);
        // Clear, an unknown operation, and a scan of the empty table.
        add_row(mk_cmd(tcts_pkg::OP_CLEAR, 16'h0000, 3'd0, 3'd0, 8'd0, 16'd0,
                       1'b0, 1'b0, 48'd1801), 1'b0, tcts_pkg::EV_ADDED);
        add_row(mk_cmd(OP_UNKNOWN, 16'hFFFF, 3'd7, 3'd7, 8'd255, 16'hFFFF,
                       1'b1, 1'b1, 48'd1801), 1'b0, tcts_pkg::EV_ADDED);
        add_row(mk_cmd(tcts_pkg::OP_SCAN, 16'h0000, 3'd0, 3'd0, 8'd0, 16'd0,
                       1'b0, 1'b0, 48'd1802), 1'b0, tcts_pkg::EV_ADDED);
        // Fill the table, overflow it, then scan with every entry reporting.
        for (int k = 0; k < tcts_pkg::TABLE_DEPTH; k++)
            add_row(mk_cmd(tcts_pkg::OP_INSERT, 16'h0100 + 16'(k), 3'(k), 3'(k + 3),
                           8'(k * 16), 16'(k * 100), 1'b0, 1'b1, 48'd2000),
                    1'b1, tcts_pkg::EV_ADDED);
        add_row(mk_cmd(tcts_pkg::OP_INSERT, 16'hABCD, 3'd4, 3'd1, 8'd99, 16'd7,
                       1'b1, 1'b1, 48'd2000), 1'b1, tcts_pkg::EV_DROPPED);
        add_row(mk_cmd(tcts_pkg::OP_SCAN, 16'h0000, 3'd0, 3'd0, 8'd0, 16'd0,
                       1'b0, 1'b0, 48'd2800), 1'b0, tcts_pkg::EV_ADDED);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[k])
            drive_cmd(directed[k]);
        drain_results();

        // Random phases, each under its own stop hold setting.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                    new_hold = '0;
                1:
                begin
                    new_hold = '1;
                    idle_on  = 1'b0;
                end
                2:
                begin
                    new_hold = tcts_pkg::HOLD_W'($urandom);
                    base = {1'b0, 15'($urandom), 32'($urandom)};
                    if (base > now_ms)
                        now_ms = base;
                end
                default:
                begin
                    new_hold = tcts_pkg::STOP_HOLD_RST;
                    now_ms   = 48'hFFFF_F000_0000;
                end
            endcase
            cfg_write(HOLD_ADDR, 32'(new_hold));
            if (ph == 0)
                cfg_write(SPARE_ADDR, $urandom);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                row.cmd   = next_random_cmd();
                row.typed = 1'b0;
                row.ev    = tcts_pkg::EV_ADDED;
                drive_cmd(row);
            end
            drain_results();
            idle_on = 1'b1;
        end

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
